// ===== rtl/core/dps_pkg.sv =====
`timescale 1ns / 1ps
// dps_pkg: constants, micro-op encoding and microcode ROM for the double pendulum stepper.
// Depends on nothing; used by double_pendulum_step, double_pendulum_checker and the testbench.
package dps_pkg;

    typedef logic signed [33:0] word_t;
    typedef logic [5:0]         src_t;
    typedef logic [5:0]         pc_t;

    typedef enum logic [3:0] {
        OP_ADD, OP_SUB, OP_ADDW, OP_SUBW, OP_MUL, OP_DAMP,
        OP_WRAP, OP_SINCOS, OP_DIV, OP_END
    } op_t;

    typedef struct packed {
        op_t  op;
        src_t a;
        src_t b;
        src_t dst;
    } uop_t;

    // config register indexes
    localparam logic [2:0] REG_GRAVITY  = 3'd0;
    localparam logic [2:0] REG_MASS_UP  = 3'd1;
    localparam logic [2:0] REG_MASS_LO  = 3'd2;
    localparam logic [2:0] REG_LEN_UP   = 3'd3;
    localparam logic [2:0] REG_LEN_LO   = 3'd4;
    localparam logic [2:0] REG_DAMPING  = 3'd5;

    // fixed point constants
    localparam word_t Q_MAX      = 34'sd2147483647;
    localparam word_t Q_MIN      = -34'sd2147483648;
    localparam logic signed [65:0] Q_MAX_W = 66'sd2147483647;
    localparam logic signed [65:0] Q_MIN_W = -66'sd2147483648;
    localparam logic signed [20:0] PI_Q      = 21'sd205887;
    localparam logic signed [20:0] TWO_PI_Q  = 21'sd411775;
    localparam logic signed [19:0] HALF_PI_C = 20'sd102944;
    localparam logic signed [19:0] PI_C      = 20'sd205887;
    localparam logic signed [19:0] ONE_C     = 20'sd65536;
    localparam logic signed [19:0] CORDIC_X0 = 20'sd39797;
    localparam logic [34:0] TWO_PI_W  = 35'd411775;
    localparam int unsigned CORDIC_STEPS = 16;
    localparam int unsigned WRAP_STEPS   = 16;
    localparam int unsigned DIV_STEPS    = 48;

    // operand / destination space: 0..31 scratch, above that named values
    localparam src_t R_RAW   = 6'd0;
    localparam src_t R_D     = 6'd1;
    localparam src_t R_A2B   = 6'd2;
    localparam src_t R_D2    = 6'd3;
    localparam src_t R_S1    = 6'd4;
    localparam src_t R_C1    = 6'd5;
    localparam src_t R_SD    = 6'd6;
    localparam src_t R_CD    = 6'd7;
    localparam src_t R_S12   = 6'd8;
    localparam src_t R_C12   = 6'd9;
    localparam src_t R_S2D   = 6'd10;
    localparam src_t R_C2D   = 6'd11;
    localparam src_t R_MM    = 6'd12;
    localparam src_t R_DEN   = 6'd13;
    localparam src_t R_W1S   = 6'd14;
    localparam src_t R_W2S   = 6'd15;
    localparam src_t R_TA    = 6'd16;
    localparam src_t R_TB    = 6'd17;
    localparam src_t R_W2L   = 6'd18;
    localparam src_t R_W1L   = 6'd19;
    localparam src_t R_INNER = 6'd20;
    localparam src_t R_SD2   = 6'd21;
    localparam src_t R_TC    = 6'd22;
    localparam src_t R_NUMA  = 6'd23;
    localparam src_t R_DENA  = 6'd24;
    localparam src_t R_MSUM  = 6'd25;
    localparam src_t R_F2    = 6'd26;
    localparam src_t R_TMP   = 6'd27;
    localparam src_t R_STEP  = 6'd28;
    localparam src_t SRC_SPECIAL = 6'd32;
    localparam src_t S_ANG_A  = 6'd32;
    localparam src_t S_ANG_B  = 6'd33;
    localparam src_t S_RATE_A = 6'd34;
    localparam src_t S_RATE_B = 6'd35;
    localparam src_t S_ACC_A  = 6'd36;
    localparam src_t S_ACC_B  = 6'd37;
    localparam src_t S_ZERO   = 6'd38;
    localparam src_t S_DT     = 6'd39;
    localparam src_t S_G      = 6'd40;
    localparam src_t S_M1     = 6'd41;
    localparam src_t S_M2     = 6'd42;
    localparam src_t S_L1     = 6'd43;
    localparam src_t S_L2     = 6'd44;
    localparam src_t S_SA     = 6'd45;
    localparam src_t S_SB     = 6'd46;

    localparam pc_t PC_STEP  = 6'd0;
    localparam pc_t PC_RESET = 6'd56;

    function automatic uop_t mk(op_t op, src_t a, src_t b, src_t dst);
        uop_t u;
        u.op = op;
        u.a = a;
        u.b = b;
        u.dst = dst;
        return u;
    endfunction

    function automatic uop_t ucode(pc_t pc);
        uop_t u;
        case (pc)
            6'd0:  u = mk(OP_SUBW,   S_ANG_A,  S_ANG_B, R_RAW);
            6'd1:  u = mk(OP_WRAP,   R_RAW,    S_ZERO,  R_D);
            6'd2:  u = mk(OP_SUBW,   R_RAW,    S_ANG_B, R_A2B);
            6'd3:  u = mk(OP_WRAP,   R_A2B,    S_ZERO,  R_A2B);
            6'd4:  u = mk(OP_ADDW,   R_D,      R_D,     R_D2);
            6'd5:  u = mk(OP_WRAP,   R_D2,     S_ZERO,  R_D2);
            6'd6:  u = mk(OP_SINCOS, S_ANG_A,  S_ZERO,  R_S1);
            6'd7:  u = mk(OP_SINCOS, R_D,      S_ZERO,  R_SD);
            6'd8:  u = mk(OP_SINCOS, R_A2B,    S_ZERO,  R_S12);
            6'd9:  u = mk(OP_SINCOS, R_D2,     S_ZERO,  R_S2D);
            6'd10: u = mk(OP_ADD,    S_M1,     S_M1,    R_MM);
            6'd11: u = mk(OP_ADD,    R_MM,     S_M2,    R_MM);
            6'd12: u = mk(OP_MUL,    S_M2,     R_C2D,   R_DEN);
            6'd13: u = mk(OP_SUB,    R_MM,     R_DEN,   R_DEN);
            6'd14: u = mk(OP_MUL,    S_RATE_A, S_RATE_A, R_W1S);
            6'd15: u = mk(OP_MUL,    S_RATE_B, S_RATE_B, R_W2S);
            6'd16: u = mk(OP_MUL,    S_G,      R_MM,    R_TA);
            6'd17: u = mk(OP_MUL,    R_TA,     R_S1,    R_TA);
            6'd18: u = mk(OP_MUL,    S_M2,     S_G,     R_TB);
            6'd19: u = mk(OP_MUL,    R_TB,     R_S12,   R_TB);
            6'd20: u = mk(OP_MUL,    R_W2S,    S_L2,    R_W2L);
            6'd21: u = mk(OP_MUL,    R_W1S,    S_L1,    R_W1L);
            6'd22: u = mk(OP_MUL,    R_W1L,    R_CD,    R_INNER);
            6'd23: u = mk(OP_ADD,    R_W2L,    R_INNER, R_INNER);
            6'd24: u = mk(OP_ADD,    R_SD,     R_SD,    R_SD2);
            6'd25: u = mk(OP_MUL,    R_SD2,    S_M2,    R_TC);
            6'd26: u = mk(OP_MUL,    R_TC,     R_INNER, R_TC);
            6'd27: u = mk(OP_SUB,    S_ZERO,   R_TA,    R_NUMA);
            6'd28: u = mk(OP_SUB,    R_NUMA,   R_TB,    R_NUMA);
            6'd29: u = mk(OP_SUB,    R_NUMA,   R_TC,    R_NUMA);
            6'd30: u = mk(OP_MUL,    S_L1,     R_DEN,   R_DENA);
            6'd31: u = mk(OP_DIV,    R_NUMA,   R_DENA,  S_ACC_A);
            6'd32: u = mk(OP_ADD,    S_M1,     S_M2,    R_MSUM);
            6'd33: u = mk(OP_MUL,    R_W1L,    R_MSUM,  R_F2);
            6'd34: u = mk(OP_MUL,    S_G,      R_MSUM,  R_TMP);
            6'd35: u = mk(OP_MUL,    R_TMP,    R_C1,    R_TMP);
            6'd36: u = mk(OP_ADD,    R_F2,     R_TMP,   R_F2);
            6'd37: u = mk(OP_MUL,    R_W2L,    S_M2,    R_TMP);
            6'd38: u = mk(OP_MUL,    R_TMP,    R_CD,    R_TMP);
            6'd39: u = mk(OP_ADD,    R_F2,     R_TMP,   R_F2);
            6'd40: u = mk(OP_MUL,    R_SD2,    R_F2,    R_F2);
            6'd41: u = mk(OP_MUL,    S_L2,     R_DEN,   R_TMP);
            6'd42: u = mk(OP_DIV,    R_F2,     R_TMP,   S_ACC_B);
            6'd43: u = mk(OP_MUL,    S_ACC_A,  S_DT,    R_STEP);
            6'd44: u = mk(OP_ADD,    S_RATE_A, R_STEP,  S_RATE_A);
            6'd45: u = mk(OP_MUL,    S_ACC_B,  S_DT,    R_STEP);
            6'd46: u = mk(OP_ADD,    S_RATE_B, R_STEP,  S_RATE_B);
            6'd47: u = mk(OP_MUL,    S_RATE_A, S_DT,    R_STEP);
            6'd48: u = mk(OP_ADDW,   S_ANG_A,  R_STEP,  R_STEP);
            6'd49: u = mk(OP_WRAP,   R_STEP,   S_ZERO,  S_ANG_A);
            6'd50: u = mk(OP_MUL,    S_RATE_B, S_DT,    R_STEP);
            6'd51: u = mk(OP_ADDW,   S_ANG_B,  R_STEP,  R_STEP);
            6'd52: u = mk(OP_WRAP,   R_STEP,   S_ZERO,  S_ANG_B);
            6'd53: u = mk(OP_DAMP,   S_RATE_A, S_ZERO,  S_RATE_A);
            6'd54: u = mk(OP_DAMP,   S_RATE_B, S_ZERO,  S_RATE_B);
            6'd56: u = mk(OP_WRAP,   S_SA,     S_ZERO,  S_ANG_A);
            6'd57: u = mk(OP_WRAP,   S_SB,     S_ZERO,  S_ANG_B);
            default: u = mk(OP_END,  S_ZERO,   S_ZERO,  S_ZERO);
        endcase
        return u;
    endfunction

    function automatic logic signed [19:0] atan_q(logic [3:0] i);
        logic signed [19:0] v;
        case (i)
            4'd0:  v = 20'sd51472;
            4'd1:  v = 20'sd30386;
            4'd2:  v = 20'sd16055;
            4'd3:  v = 20'sd8150;
            4'd4:  v = 20'sd4091;
            4'd5:  v = 20'sd2047;
            4'd6:  v = 20'sd1024;
            4'd7:  v = 20'sd512;
            4'd8:  v = 20'sd256;
            4'd9:  v = 20'sd128;
            4'd10: v = 20'sd64;
            4'd11: v = 20'sd32;
            4'd12: v = 20'sd16;
            4'd13: v = 20'sd8;
            4'd14: v = 20'sd4;
            default: v = 20'sd2;
        endcase
        return v;
    endfunction

    function automatic word_t sat_w(logic signed [65:0] v);
        word_t r;
        if (v > Q_MAX_W) r = Q_MAX;
        else if (v < Q_MIN_W) r = Q_MIN;
        else r = v[33:0];
        return r;
    endfunction

    function automatic logic signed [19:0] clamp_unit(logic signed [19:0] v);
        logic signed [19:0] r;
        if (v > ONE_C) r = ONE_C;
        else if (v < -ONE_C) r = -ONE_C;
        else r = v;
        return r;
    endfunction

endpackage

// ===== rtl/core/double_pendulum_step.sv =====
`timescale 1ns / 1ps
// double_pendulum_step: damped double pendulum, semi-implicit Euler, Q16.16.
// Depends on dps_pkg (micro-op ROM, constants, helpers).
//
//  channel   | dir | handshake                   | payload
//  ----------+-----+-----------------------------+-------------------------------------
//  s_axis    | in  | s_axis_tvalid/s_axis_tready | tdata: time_step, start angles
//            |     |                             | tuser: action (1 = load start angles)
//  m_axis    | out | m_axis_tvalid/m_axis_tready | tdata: angles, rates, accelerations
//  cfg       | in  | cfg_valid/cfg_ready         | cfg_index, cfg_data
//
// A step word runs a 55-entry microprogram on one shared datapath: a 33x33
// multiplier, a saturating adder, a shift/subtract angle wrap, a 16-iteration
// CORDIC and a restoring divider. Each micro-op passes the read, prep and
// writeback states, with its unit iterating between prep and writeback.
// The 55 step micro-ops hold two divides, five angle wraps and four CORDIC
// runs, whose cosine takes a second writeback; a start-angle word runs two
// angle wraps. s_axis_tready is high only while idle. The result sits in an
// output register; the next word is taken while it waits, and the sequencer
// holds at its end until the register is free.
// Reset (rst_n low) clears the state and loads register defaults.
module double_pendulum_step (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [79:0]  s_axis_tdata,   // [15:0] time_step, [47:16] start_angle_upper,
                                         // [79:48] start_angle_lower
    input  logic         s_axis_tuser,   // [0] action
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [191:0] m_axis_tdata,   // angle_upper, angle_lower, rate_upper,
                                         // rate_lower, accel_upper, accel_lower (32 each)
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    import dps_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_READ   = 9'b000000010,
        S_PREP   = 9'b000000100,
        S_WRAP   = 9'b000001000,
        S_CORDIC = 9'b000010000,
        S_DIV    = 9'b000100000,
        S_WB     = 9'b001000000,
        S_WB2    = 9'b010000000,
        S_OUT    = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    pc_t    pc_reg;
    logic [5:0] cnt_reg;
    logic   out_valid_reg;
    logic [191:0] out_data_reg;

    // configuration
    logic [30:0] gravity_reg, mass_up_reg, mass_lo_reg, len_up_reg, len_lo_reg;
    logic [31:0] damping_reg;

    // pendulum state
    logic signed [31:0] ang_a_reg, ang_b_reg, rate_a_reg, rate_b_reg, acc_a_reg, acc_b_reg;

    // latched input word
    logic [15:0] dt_reg;
    logic signed [31:0] sa_reg, sb_reg;

    // datapath
    word_t rf [32];
    word_t opa_reg, opb_reg;
    logic signed [65:0] prod_reg;
    logic [34:0] wm_reg;
    logic        wneg_reg;
    logic signed [19:0] cx_reg, cy_reg, cz_reg;
    logic        cneg_reg;
    logic [47:0] dq_reg;
    logic [31:0] dm_reg, rem_reg;
    logic        dneg_reg, dzero_reg;

    uop_t  cur;
    word_t spec_a, spec_b, res, cos_val, wval;
    src_t  wdst;
    logic  wen;
    logic signed [32:0] ma, mb;
    logic signed [34:0] ox;
    logic [33:0] nmag, dmag;
    logic [34:0] wc;
    logic signed [20:0] wr;
    logic signed [19:0] zf, ysh, xsh, at, sinv, cosv;
    logic [32:0] rem_sh;
    logic        dge;
    logic signed [48:0] qv;
    logic signed [65:0] mul_sh;
    logic [31:0] damp_mag;

    assign cur = ucode(pc_reg);
    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_data_reg;

    function automatic word_t special(src_t code);
        word_t v;
        case (code)
            S_ANG_A:  v = 34'(ang_a_reg);
            S_ANG_B:  v = 34'(ang_b_reg);
            S_RATE_A: v = 34'(rate_a_reg);
            S_RATE_B: v = 34'(rate_b_reg);
            S_ACC_A:  v = 34'(acc_a_reg);
            S_ACC_B:  v = 34'(acc_b_reg);
            S_DT:     v = {18'd0, dt_reg};
            S_G:      v = {3'd0, gravity_reg};
            S_M1:     v = {3'd0, mass_up_reg};
            S_M2:     v = {3'd0, mass_lo_reg};
            S_L1:     v = {3'd0, len_up_reg};
            S_L2:     v = {3'd0, len_lo_reg};
            S_SA:     v = 34'(sa_reg);
            S_SB:     v = 34'(sb_reg);
            default:  v = '0;
        endcase
        return v;
    endfunction

    assign spec_a = special(cur.a);
    assign spec_b = special(cur.b);

    // unit-side combinational pieces
    always_comb
    begin
        // multiplier operands: signed Q16.16, or magnitude x damping
        ox   = 35'(opa_reg);
        nmag = ox[34] ? 34'(-ox) : 34'(ox);
        dmag = opb_reg[33] ? 34'(-opb_reg) : 34'(opb_reg);
        if (cur.op == OP_DAMP)
        begin
            ma = {1'b0, nmag[31:0]};
            mb = {1'b0, damping_reg};
        end
        else
        begin
            ma = opa_reg[32:0];
            mb = opb_reg[32:0];
        end
        wc = TWO_PI_W << cnt_reg[3:0];
        // CORDIC fold into [-pi/2, pi/2]
        zf = opa_reg[19:0];
        ysh = cy_reg >>> cnt_reg[3:0];
        xsh = cx_reg >>> cnt_reg[3:0];
        at  = atan_q(cnt_reg[3:0]);
        rem_sh = {rem_reg, dq_reg[47]};
        dge = (rem_sh >= {1'b0, dm_reg});
    end

    // writeback value
    always_comb
    begin
        mul_sh   = prod_reg >>> 16;
        damp_mag = prod_reg[63:32];
        wr = wneg_reg ? -21'($signed({2'b00, wm_reg[18:0]}))
                      : 21'($signed({2'b00, wm_reg[18:0]}));
        if (wr > PI_Q) wr = wr - TWO_PI_Q;
        else if (wr < -PI_Q) wr = wr + TWO_PI_Q;
        qv = $signed({1'b0, dq_reg});
        if (dneg_reg) qv = -qv;
        sinv = clamp_unit(cy_reg);
        cosv = clamp_unit(cx_reg);
        if (cneg_reg)
        begin
            sinv = -sinv;
            cosv = -cosv;
        end
        cos_val = 34'(cosv);
        case (cur.op)
            OP_ADD:    res = sat_w(66'(opa_reg) + 66'(opb_reg));
            OP_SUB:    res = sat_w(66'(opa_reg) - 66'(opb_reg));
            OP_ADDW:   res = opa_reg + opb_reg;
            OP_SUBW:   res = opa_reg - opb_reg;
            OP_MUL:    res = sat_w(mul_sh);
            OP_DAMP:   res = opa_reg[33] ? -34'({2'b00, damp_mag}) : {2'b00, damp_mag};
            OP_WRAP:   res = 34'(wr);
            OP_SINCOS: res = 34'(sinv);
            OP_DIV:    res = dzero_reg ? (opa_reg[33] ? Q_MIN : Q_MAX) : sat_w(66'(qv));
            default:   res = '0;
        endcase
        wen  = (state_reg == S_WB) || (state_reg == S_WB2);
        wdst = (state_reg == S_WB2) ? cur.dst + 6'd1 : cur.dst;
        wval = (state_reg == S_WB2) ? cos_val : res;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (s_axis_tvalid) state_next = S_READ;
            S_READ:   state_next = (cur.op == OP_END) ? S_OUT : S_PREP;
            S_PREP:
            begin
                case (cur.op)
                    OP_WRAP:   state_next = S_WRAP;
                    OP_SINCOS: state_next = S_CORDIC;
                    OP_DIV:    state_next = S_DIV;
                    default:   state_next = S_WB;
                endcase
            end
            S_WRAP:   if (cnt_reg == 6'd0) state_next = S_WB;
            S_CORDIC: if (cnt_reg == 6'(CORDIC_STEPS - 1)) state_next = S_WB;
            S_DIV:    if (cnt_reg == 6'd0) state_next = S_WB;
            S_WB:     state_next = (cur.op == OP_SINCOS) ? S_WB2 : S_READ;
            S_WB2:    state_next = S_READ;
            S_OUT:    if (!out_valid_reg || m_axis_tready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pc_reg        <= PC_STEP;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            gravity_reg   <= 31'd642253;
            mass_up_reg   <= 31'd65536;
            mass_lo_reg   <= 31'd65536;
            len_up_reg    <= 31'd65536;
            len_lo_reg    <= 31'd65536;
            damping_reg   <= 32'd4294924346;
            ang_a_reg     <= '0;
            ang_b_reg     <= '0;
            rate_a_reg    <= '0;
            rate_b_reg    <= '0;
            acc_a_reg     <= '0;
            acc_b_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_GRAVITY: gravity_reg <= cfg_data[30:0];
                    REG_MASS_UP: mass_up_reg <= cfg_data[30:0];
                    REG_MASS_LO: mass_lo_reg <= cfg_data[30:0];
                    REG_LEN_UP:  len_up_reg  <= cfg_data[30:0];
                    REG_LEN_LO:  len_lo_reg  <= cfg_data[30:0];
                    REG_DAMPING: damping_reg <= cfg_data;
                    default:     ;
                endcase
            end
            // load a new result, or drop the one taken downstream
            if (state_reg == S_OUT && (!out_valid_reg || m_axis_tready))
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        if (s_axis_tuser)
                        begin
                            pc_reg     <= PC_RESET;
                            rate_a_reg <= '0;
                            rate_b_reg <= '0;
                            acc_a_reg  <= '0;
                            acc_b_reg  <= '0;
                        end
                        else
                        begin
                            pc_reg <= PC_STEP;
                        end
                    end
                end
                S_PREP:
                begin
                    case (cur.op)
                        OP_WRAP:   cnt_reg <= 6'(WRAP_STEPS - 1);
                        OP_DIV:    cnt_reg <= 6'(DIV_STEPS - 1);
                        default:   cnt_reg <= '0;
                    endcase
                end
                S_WRAP, S_DIV: cnt_reg <= cnt_reg - 6'd1;
                S_CORDIC:      cnt_reg <= cnt_reg + 6'd1;
                S_WB:          if (cur.op != OP_SINCOS) pc_reg <= pc_reg + 6'd1;
                S_WB2:         pc_reg <= pc_reg + 6'd1;
                default: ;
            endcase
            if (wen)
            begin
                case (wdst)
                    S_ANG_A:  ang_a_reg  <= wval[31:0];
                    S_ANG_B:  ang_b_reg  <= wval[31:0];
                    S_RATE_A: rate_a_reg <= wval[31:0];
                    S_RATE_B: rate_b_reg <= wval[31:0];
                    S_ACC_A:  acc_a_reg  <= wval[31:0];
                    S_ACC_B:  acc_b_reg  <= wval[31:0];
                    default:  ;
                endcase
            end
        end
    end

    // datapath registers and scratch memory
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && s_axis_tvalid)
        begin
            dt_reg <= s_axis_tdata[15:0];
            sa_reg <= s_axis_tdata[47:16];
            sb_reg <= s_axis_tdata[79:48];
        end
        if (state_reg == S_OUT && (!out_valid_reg || m_axis_tready))
        begin
            out_data_reg <= {acc_b_reg, acc_a_reg, rate_b_reg, rate_a_reg,
                             ang_b_reg, ang_a_reg};
        end
        if (state_reg == S_READ)
        begin
            opa_reg <= (cur.a < SRC_SPECIAL) ? rf[cur.a[4:0]] : spec_a;
            opb_reg <= (cur.b < SRC_SPECIAL) ? rf[cur.b[4:0]] : spec_b;
        end
        if (wen && wdst < SRC_SPECIAL)
        begin
            rf[wdst[4:0]] <= wval;
        end
        case (state_reg)
            S_PREP:
            begin
                prod_reg  <= 66'(ma) * 66'(mb);
                wm_reg    <= 35'(nmag);
                wneg_reg  <= opa_reg[33];
                cx_reg    <= CORDIC_X0;
                cy_reg    <= '0;
                if (zf > HALF_PI_C)
                begin
                    cz_reg   <= zf - PI_C;
                    cneg_reg <= 1'b1;
                end
                else if (zf < -HALF_PI_C)
                begin
                    cz_reg   <= zf + PI_C;
                    cneg_reg <= 1'b1;
                end
                else
                begin
                    cz_reg   <= zf;
                    cneg_reg <= 1'b0;
                end
                dq_reg    <= {nmag[31:0], 16'd0};
                dm_reg    <= dmag[31:0];
                rem_reg   <= '0;
                dneg_reg  <= opa_reg[33] ^ opb_reg[33];
                dzero_reg <= (opb_reg == '0);
            end
            S_WRAP:
            begin
                if (wm_reg >= wc) wm_reg <= wm_reg - wc;
            end
            S_CORDIC:
            begin
                if (cz_reg >= 0)
                begin
                    cx_reg <= cx_reg - ysh;
                    cy_reg <= cy_reg + xsh;
                    cz_reg <= cz_reg - at;
                end
                else
                begin
                    cx_reg <= cx_reg + ysh;
                    cy_reg <= cy_reg - xsh;
                    cz_reg <= cz_reg + at;
                end
            end
            S_DIV:
            begin
                rem_reg <= dge ? 32'(rem_sh - {1'b0, dm_reg}) : rem_sh[31:0];
                dq_reg  <= {dq_reg[46:0], dge};
            end
            default: ;
        endcase
    end

    // checks
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> state_reg == S_READ)
        else $error("accepted word did not start the sequencer");

    a_cordic_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CORDIC |-> cnt_reg < 6'(CORDIC_STEPS))
        else $error("CORDIC counter overran");

    a_wrap_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WB && cur.op == OP_WRAP |->
        (res >= -34'sd205887 && res <= 34'sd205887))
        else $error("wrapped angle out of range");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_OUT && (!out_valid_reg || m_axis_tready) |=> m_axis_tvalid)
        else $error("result not presented");

endmodule

// ===== tb/sv/double_pendulum_checker.sv =====
`timescale 1ns / 1ps
// double_pendulum_checker: watches the input, config and result channels of
// double_pendulum_step, predicts each result word in Q16.16 and compares it.
// Depends on dps_pkg for the register index names.
module double_pendulum_checker
    import dps_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [79:0]  s_axis_tdata,
    input  logic         s_axis_tuser,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [191:0] m_axis_tdata,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    output int           fail_count,
    output int           pending
);

    typedef logic signed [63:0] q64_t;

    localparam q64_t QMAX = 64'sd2147483647;
    localparam q64_t QMIN = -64'sd2147483648;
    localparam q64_t PI = 64'sd205887;
    localparam q64_t HPI = 64'sd102944;
    localparam q64_t TPI = 64'sd411775;

    q64_t grav, m_up, m_lo, l_up, l_lo, damp_frac;
    q64_t ang_a, ang_b, w_a, w_b, acc_a, acc_b;
    logic [191:0] state_q[$];
    int unsigned result_no;

    function automatic q64_t sat(q64_t v);
        return v > QMAX ? QMAX : (v < QMIN ? QMIN : v);
    endfunction

    function automatic q64_t qm(q64_t a, q64_t b);
        return sat((a * b) >>> 16);
    endfunction

    function automatic q64_t qdv(q64_t n, q64_t d);
        if (d == 0)
            return n >= 0 ? QMAX : QMIN;
        return sat((n * 64'sd65536) / d);
    endfunction

    function automatic q64_t wrap(q64_t v);
        q64_t r;
        r = v % TPI;
        if (r >= TPI - PI)
            r -= TPI;
        else if (r < -PI)
            r += TPI;
        return r;
    endfunction

    // CORDIC sine/cosine, folded into [-pi/2, pi/2]
    task automatic sincos(input q64_t ang, output q64_t s, output q64_t c);
        q64_t z, x, y, nx;
        q64_t atan_lut[16];
        logic flip;
        atan_lut = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                     256, 128, 64, 32, 16, 8, 4, 2};
        z = wrap(ang);
        x = 39797;
        y = 0;
        flip = 1'b0;
        if (z > HPI)
        begin
            z -= PI;
            flip = 1'b1;
        end
        else if (z < -HPI)
        begin
            z += PI;
            flip = 1'b1;
        end
        for (int i = 0; i < 16; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= atan_lut[i];
            end
            else
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += atan_lut[i];
            end
            x = nx;
        end
        x = x > 65536 ? 65536 : (x < -65536 ? -65536 : x);
        y = y > 65536 ? 65536 : (y < -65536 ? -65536 : y);
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    function automatic q64_t damp(q64_t w);
        logic [63:0] mag;
        q64_t r;
        mag = w < 0 ? -w : w;
        r = q64_t'((mag * 64'(damp_frac)) >> 32);
        return w < 0 ? -r : r;
    endfunction

    task automatic advance_pendulum(input logic [79:0] d, input logic load);
        q64_t dt, s1, c1, sd, cd, s12, c12, s2d, c2d, dd, mm, den;
        q64_t w1s, w2s, ta, tb, inner, tc, num, msum, f2, f3;
        if (load)
        begin
            ang_a = wrap(q64_t'($signed(d[47:16])));
            ang_b = wrap(q64_t'($signed(d[79:48])));
            w_a = 0;
            w_b = 0;
            acc_a = 0;
            acc_b = 0;
        end
        else
        begin
            dt = q64_t'(d[15:0]);
            dd = wrap(ang_a - ang_b);
            sincos(ang_a, s1, c1);
            sincos(dd, sd, cd);
            sincos(ang_a - ang_b - ang_b, s12, c12);
            sincos(dd + dd, s2d, c2d);
            mm = sat(sat(m_up + m_up) + m_lo);
            den = sat(mm - qm(m_lo, c2d));
            w1s = qm(w_a, w_a);
            w2s = qm(w_b, w_b);
            ta = qm(qm(grav, mm), s1);
            tb = qm(qm(m_lo, grav), s12);
            inner = sat(qm(w2s, l_lo) + qm(qm(w1s, l_up), cd));
            tc = qm(qm(sat(sd + sd), m_lo), inner);
            num = sat(sat(sat(-ta) - tb) - tc);
            acc_a = qdv(num, qm(l_up, den));
            msum = sat(m_up + m_lo);
            f2 = sat(qm(qm(w1s, l_up), msum) + qm(qm(grav, msum), c1));
            f3 = qm(qm(qm(w2s, l_lo), m_lo), cd);
            num = qm(sat(sd + sd), sat(f2 + f3));
            acc_b = qdv(num, qm(l_lo, den));
            w_a = sat(w_a + qm(acc_a, dt));
            w_b = sat(w_b + qm(acc_b, dt));
            ang_a = wrap(ang_a + qm(w_a, dt));
            ang_b = wrap(ang_b + qm(w_b, dt));
            w_a = damp(w_a);
            w_b = damp(w_b);
        end
        state_q.push_back({acc_b[31:0], acc_a[31:0], w_b[31:0], w_a[31:0],
                           ang_b[31:0], ang_a[31:0]});
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("MISMATCH result %0d %s: got %h expected %h", result_no, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic [191:0] want;
        string names[6];
        names = '{"angle_upper", "angle_lower", "rate_upper", "rate_lower",
                  "accel_upper", "accel_lower"};
        if (!rst_n)
        begin
            grav = 642253;
            m_up = 65536;
            m_lo = 65536;
            l_up = 65536;
            l_lo = 65536;
            damp_frac = 64'd4294924346;
            ang_a = 0; ang_b = 0; w_a = 0; w_b = 0; acc_a = 0; acc_b = 0;
            state_q.delete();
            fail_count = 0;
            result_no = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_GRAVITY: grav = q64_t'(cfg_data[30:0]);
                    REG_MASS_UP: m_up = q64_t'(cfg_data[30:0]);
                    REG_MASS_LO: m_lo = q64_t'(cfg_data[30:0]);
                    REG_LEN_UP:  l_up = q64_t'(cfg_data[30:0]);
                    REG_LEN_LO:  l_lo = q64_t'(cfg_data[30:0]);
                    REG_DAMPING: damp_frac = q64_t'(cfg_data);
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (state_q.size() == 0)
                begin
                    $display("UNEXPECTED result word %0d: %h", result_no, m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    want = state_q.pop_front();
                    for (int f = 0; f < 6; f++)
                        if (m_axis_tdata[32*f +: 32] !== want[32*f +: 32])
                            report(names[f], m_axis_tdata[32*f +: 32], want[32*f +: 32]);
                end
                result_no++;
            end
            if (s_axis_tvalid && s_axis_tready)
                advance_pendulum(s_axis_tdata, s_axis_tuser);
        end
        pending = state_q.size();
    end

endmodule

// ===== tb/sv/tb_double_pendulum_step.sv =====
`timescale 1ns / 1ps
// tb_double_pendulum_step: stimulus and verdict for double_pendulum_step.
// Depends on dps_pkg, double_pendulum_step and double_pendulum_checker.
module tb_double_pendulum_step;
    import dps_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [79:0]  s_axis_tdata;   // [15:0] time_step, [47:16] start_angle_upper,
                                  // [79:48] start_angle_lower
    logic         s_axis_tuser;   // [0] action
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [191:0] m_axis_tdata;   // angle_upper, angle_lower, rate_upper, rate_lower,
                                  // accel_upper, accel_lower
    logic         cfg_valid;
    logic         cfg_ready;
    logic [2:0]   cfg_index;
    logic [31:0]  cfg_data;
    int           fail_count;
    int           pending;
    int           idle_cycles;
    logic         calm;           // no idling on either side while set

    localparam logic ACT_STEP = 1'b0;
    localparam logic ACT_LOAD = 1'b1;

    double_pendulum_step dut (.*);

    double_pendulum_checker u_checker (.*);

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // result side backpressure
    always @(posedge clk)
        m_axis_tready <= calm || ($urandom_range(99) >= 33);

    // watchdog: cycles with no handshake on any channel
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // valid stays up after the handshake; the next word, an idle cycle
    // or drain() takes it down, so it is assigned once per edge
    task automatic send_word(input logic act, input logic [15:0] dt,
                             input logic [31:0] sa, input logic [31:0] sb);
        while (!calm && $urandom_range(99) < 33)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {sb, sa, dt};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // valid is dropped at the end of physics_setup
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // drop valid, wait until no result is pending, then pause before the next phase
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (500) @(posedge clk);
    endtask

    function automatic logic [15:0] rand_dt();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0)
            return 16'($urandom);
        return 16'($urandom_range(3000));
    endfunction

    function automatic logic [31:0] rand_angle();
        if ($urandom_range(9) == 0)
            return $urandom;
        return 32'($signed($urandom_range(900000)) - 450000);
    endfunction

    task automatic physics_setup(input int kind);
        case (kind)
            0:
            begin
                write_reg(REG_GRAVITY, 32'd642253);
                write_reg(REG_MASS_UP, 32'd65536);
                write_reg(REG_MASS_LO, 32'd65536);
                write_reg(REG_LEN_UP, 32'd65536);
                write_reg(REG_LEN_LO, 32'd65536);
                write_reg(REG_DAMPING, 32'd4294924346);
            end
            1:
            begin
                // extremes: saturating values, full damping word
                write_reg(REG_GRAVITY, 32'h7fffffff);
                write_reg(REG_MASS_UP, 32'hffffffff);
                write_reg(REG_MASS_LO, 32'h7fffffff);
                write_reg(REG_LEN_UP, 32'h7fffffff);
                write_reg(REG_LEN_LO, 32'h7fffffff);
                write_reg(REG_DAMPING, 32'hffffffff);
            end
            2:
            begin
                // zero upper mass and length, lower ones at 1 LSB, force the zero-denominator path
                write_reg(REG_GRAVITY, 32'd0);
                write_reg(REG_MASS_UP, 32'd0);
                write_reg(REG_MASS_LO, 32'd1);
                write_reg(REG_LEN_UP, 32'd0);
                write_reg(REG_LEN_LO, 32'd1);
                write_reg(REG_DAMPING, 32'd0);
            end
            default:
            begin
                write_reg(REG_GRAVITY, $urandom_range(2000000));
                write_reg(REG_MASS_UP, $urandom_range(400000, 1000));
                write_reg(REG_MASS_LO, $urandom_range(400000, 1000));
                write_reg(REG_LEN_UP, $urandom_range(400000, 1000));
                write_reg(REG_LEN_LO, $urandom_range(400000, 1000));
                write_reg(REG_DAMPING, $urandom | 32'hf0000000);
                // unknown index must be ignored
                write_reg(3'd6 + 3'($urandom_range(1)), $urandom);
            end
        endcase
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = ACT_STEP;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        idle_cycles = 0;
        calm = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: defaults, field extremes, step with zero state
        send_word(ACT_STEP, 16'd0, 32'd0, 32'd0);
        send_word(ACT_LOAD, 16'hffff, 32'h7fffffff, 32'h80000000);
        send_word(ACT_STEP, 16'hffff, 32'hffffffff, 32'hffffffff);
        send_word(ACT_LOAD, 16'd0, 32'd102944, 32'hfffcdba1);
        send_word(ACT_STEP, 16'd655, 32'd0, 32'd0);
        send_word(ACT_STEP, 16'hffff, 32'd0, 32'd0);
        send_word(ACT_LOAD, 16'd0, 32'd205887, 32'd411775);
        send_word(ACT_STEP, 16'd1000, 32'd0, 32'd0);
        drain();
        physics_setup(1);
        send_word(ACT_LOAD, 16'd0, 32'd70000, 32'd140000);
        repeat (3) send_word(ACT_STEP, 16'hffff, 32'd0, 32'd0);
        drain();
        physics_setup(2);
        send_word(ACT_LOAD, 16'd0, 32'd50000, 32'hffff0000);
        repeat (3) send_word(ACT_STEP, 16'd30000, 32'd0, 32'd0);
        drain();

        // random phases: mostly trajectories from a fresh load
        for (int phase = 0; phase < 8; phase++)
        begin
            physics_setup(phase == 0 ? 0 : 3);
            calm = (phase == 4);
            for (int n = 0; n < 72; n++)
            begin
                if (n % 24 == 0 || $urandom_range(49) == 0)
                    send_word(ACT_LOAD, 16'($urandom), rand_angle(), rand_angle());
                else
                    send_word(ACT_STEP, rand_dt(), $urandom, $urandom);
            end
            drain();
        end
        calm = 1'b0;

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
